// ===== rtl/apjb_pkg.sv =====
// ---------------------------------------------------------------------------
// apjb_pkg
// Shared types, constants and helpers of the audio playout jitter buffer.
// ---------------------------------------------------------------------------
package apjb_pkg;

    // ring geometry
    localparam int RING_BYTES = 65536;
    localparam int RING_HALF  = RING_BYTES / 2;
    localparam int PTR_W      = $clog2(RING_BYTES);
    localparam int FILL_W     = PTR_W + 1;

    // configuration field widths and reset values
    localparam int RATE_W  = 16;
    localparam int MS_W    = 12;
    localparam int MIN_W   = 17;
    localparam int CFG_W   = 17;
    localparam int CIDX_W  = 2;

    localparam logic [RATE_W-1:0] RATE_LO        = RATE_W'(8000);
    localparam logic [RATE_W-1:0] RATE_HI        = RATE_W'(48000);
    localparam logic [MS_W-1:0]   PREBUF_MS_RST  = MS_W'(1800);
    localparam logic [MS_W-1:0]   REFILL_MS_RST  = MS_W'(700);
    localparam logic [MIN_W-1:0]  MIN_START_RST  = MIN_W'(8192);

    // threshold arithmetic: bytes/s times ms, then divide by 1000
    localparam int BPS_W       = RATE_W + 2;
    localparam int PROD_W      = BPS_W + MS_W;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd1000);
    localparam int MUL_W       = PROD_W + RECIP_W;
    localparam int Q_W         = MUL_W - RECIP_SHIFT;
    localparam logic [PROD_W-1:0] MS_PER_SEC = PROD_W'(1000);

    // cycles the threshold pipeline needs after a register changes
    localparam int SETTLE_W = 3;
    localparam logic [SETTLE_W-1:0] SETTLE_CYC = SETTLE_W'(6);

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_SAMPLE_RATE = 2'd0,
        CFG_PREBUF_MS   = 2'd1,
        CFG_REFILL_MS   = 2'd2,
        CFG_MIN_START   = 2'd3
    } t_cfg_idx;

    // event codes
    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_PUSH   = 3'd1,
        OP_PULL   = 3'd2,
        OP_FINISH = 3'd3,
        OP_ABORT  = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] push_byte;
    } t_item;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              out_valid;
        logic              accepted;
        logic              playing;
        logic              drained_flag;
        logic              underrun_event;
        logic [15:0]       underrun_total;
        logic [FILL_W-1:0] fill_level;
        logic              session_on;
    } t_result;

    typedef struct packed {
        logic [RATE_W-1:0] sample_rate;
        logic [MS_W-1:0]   prebuffer_ms;
        logic [MS_W-1:0]   refill_ms;
        logic [MIN_W-1:0]  min_start_bytes;
    } t_cfg;

    typedef struct packed {
        logic [Q_W-1:0] prebuf;
        logic [Q_W-1:0] refill;
    } t_thresh;

    // sample rate inside the supported band
    function automatic logic rate_ok(input logic [RATE_W-1:0] rate);
        return (rate >= RATE_LO) && (rate <= RATE_HI);
    endfunction

endpackage

// ===== rtl/apjb_thresh.sv =====
// ---------------------------------------------------------------------------
// apjb_thresh
// Pipelined start thresholds: bytes/s times ms, divide by 1000 through a
// reciprocal multiply with one correction step, cap prebuffer, floor both.
// ---------------------------------------------------------------------------
module apjb_thresh (
    input  logic             i_clk,
    input  apjb_pkg::t_cfg   i_cfg,
    output apjb_pkg::t_thresh o_thr
);
    import apjb_pkg::*;

    logic [BPS_W-1:0]  bps;
    logic              rate_valid;
    logic [PROD_W-1:0] r_prod  [2];
    logic [MUL_W-1:0]  r_mul   [2];
    logic [Q_W-1:0]    r_qe    [2];
    logic [Q_W-1:0]    r_q     [2];
    logic [PROD_W-1:0] rem     [2];
    logic [Q_W-1:0]    pre_cap;
    logic [Q_W-1:0]    min_q;
    t_thresh           r_thr;

    // bytes per second, zero for a rate outside the band
    assign rate_valid = rate_ok(i_cfg.sample_rate);
    assign bps        = rate_valid ? {i_cfg.sample_rate, 2'b00} : '0;

    // lane 0 prebuffer, lane 1 refill
    always_ff @(posedge i_clk) begin
        r_prod[0] <= PROD_W'(bps) * PROD_W'(i_cfg.prebuffer_ms);
        r_prod[1] <= PROD_W'(bps) * PROD_W'(i_cfg.refill_ms);
        for (int l = 0; l < 2; l++) begin
            r_mul[l] <= MUL_W'(r_prod[l]) * MUL_W'(RECIP);
            r_qe[l]  <= r_mul[l][MUL_W-1:RECIP_SHIFT];
            r_q[l]   <= (rem[l] >= MS_PER_SEC) ? r_qe[l] + Q_W'(1) : r_qe[l];
        end
    end

    // remainder of the quotient estimate, which is low by at most one
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            rem[l] = r_prod[l] - PROD_W'(PROD_W'(r_qe[l]) * MS_PER_SEC);
        end
    end

    // cap the prebuffer at half the ring, floor both at the minimum
    assign min_q   = Q_W'(i_cfg.min_start_bytes);
    assign pre_cap = (r_q[0] > Q_W'(RING_HALF)) ? Q_W'(RING_HALF) : r_q[0];

    always_ff @(posedge i_clk) begin
        if (!rate_valid) begin
            r_thr.prebuf <= '0;
        end else begin
            r_thr.prebuf <= (pre_cap < min_q) ? min_q : pre_cap;
        end
        r_thr.refill <= (r_q[1] < min_q) ? min_q : r_q[1];
    end

    assign o_thr = r_thr;

endmodule

// ===== rtl/audio_playout_jitter_buffer.sv =====
// A result strobes on o_result_valid in the cycle after its item is taken.
// One item per cycle while busy is low; each item does at most one ring write.
// Busy is high during a configuration write and, after it or after reset, until the
// settle counter runs down to zero, while the threshold pipeline recomputes.
// Reset is synchronous active low: empty ring, no session, drained, count zero.
// The receiver cannot stall; every result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
// audio_playout_jitter_buffer
// Byte ring between an audio producer and a speaker, with prebuffering,
// underrun counting and refill before playback resumes.
// ---------------------------------------------------------------------------
module audio_playout_jitter_buffer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  apjb_pkg::t_item                i_item,
    output logic                           o_result_valid,
    output apjb_pkg::t_result              o_result,
    input  logic                           i_cfg_we,
    input  logic [apjb_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  logic [apjb_pkg::CFG_W-1:0]     i_cfg_data
);
    import apjb_pkg::*;

    // configuration and threshold state
    t_cfg                r_cfg;
    t_thresh             thr;
    logic [SETTLE_W-1:0] r_settle;

    // ring memory
    logic [7:0]       r_ring [RING_BYTES];
    logic [7:0]       r_rd_data;

    // session state
    logic [PTR_W-1:0]  r_read_ptr,  n_read_ptr;
    logic [PTR_W-1:0]  r_write_ptr, n_write_ptr;
    logic [FILL_W-1:0] r_used,      n_used;
    logic              r_active,    n_active;
    logic              r_pdone,     n_pdone;
    logic              r_started,   n_started;
    logic              r_refill,    n_refill;
    logic              r_in_ur,     n_in_ur;
    logic              r_drained,   n_drained;
    logic [15:0]       r_ur_cnt,    n_ur_cnt;

    // per item result flags
    logic r_res_valid, r_out_valid, r_accepted, r_ur_event;
    logic take, wr_en, pop, accepted, ur_event, go;
    logic [Q_W-1:0] cur_thr;

    assign busy = (r_settle != '0) || i_cfg_we;
    assign take = start && !busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_rate     <= '0;
            r_cfg.prebuffer_ms    <= PREBUF_MS_RST;
            r_cfg.refill_ms       <= REFILL_MS_RST;
            r_cfg.min_start_bytes <= MIN_START_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SAMPLE_RATE: r_cfg.sample_rate     <= i_cfg_data[RATE_W-1:0];
                CFG_PREBUF_MS:   r_cfg.prebuffer_ms    <= i_cfg_data[MS_W-1:0];
                CFG_REFILL_MS:   r_cfg.refill_ms       <= i_cfg_data[MS_W-1:0];
                CFG_MIN_START:   r_cfg.min_start_bytes <= i_cfg_data[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    // hold off items until thresholds reflect the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_CYC;
        end else if (i_cfg_we) begin
            r_settle <= SETTLE_CYC;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - SETTLE_W'(1);
        end
    end

    apjb_thresh u_thresh (
        .i_clk (i_clk),
        .i_cfg (r_cfg),
        .o_thr (thr)
    );

    assign cur_thr = r_refill ? thr.refill : thr.prebuf;

    // event decode and next session state
    always_comb begin
        n_read_ptr  = r_read_ptr;
        n_write_ptr = r_write_ptr;
        n_used      = r_used;
        n_active    = r_active;
        n_pdone     = r_pdone;
        n_started   = r_started;
        n_refill    = r_refill;
        n_in_ur     = r_in_ur;
        n_drained   = r_drained;
        n_ur_cnt    = r_ur_cnt;
        wr_en       = 1'b0;
        pop         = 1'b0;
        accepted    = 1'b0;
        ur_event    = 1'b0;
        go          = 1'b0;
        if (take) begin
            unique case (i_item.op)
                OP_START: begin
                    if (rate_ok(r_cfg.sample_rate)) begin
                        n_read_ptr  = '0;
                        n_write_ptr = '0;
                        n_used      = '0;
                        n_active    = 1'b1;
                        n_pdone     = 1'b0;
                        n_started   = 1'b0;
                        n_refill    = 1'b0;
                        n_in_ur     = 1'b0;
                        n_drained   = 1'b0;
                        accepted    = 1'b1;
                    end
                end
                OP_PUSH: begin
                    if (r_active && (r_used < FILL_W'(RING_BYTES))) begin
                        wr_en       = 1'b1;
                        n_write_ptr = r_write_ptr + PTR_W'(1);
                        n_used      = r_used + FILL_W'(1);
                        accepted    = 1'b1;
                    end
                end
                OP_PULL: begin
                    if (r_active) begin
                        go = 1'b1;
                        // waiting for the prebuffer or refill level
                        if (!r_started || r_refill) begin
                            if ((Q_W'(r_used) >= cur_thr) ||
                                (r_pdone && (r_used != '0))) begin
                                n_started = 1'b1;
                                n_refill  = 1'b0;
                                n_drained = 1'b0;
                                n_in_ur   = 1'b0;
                            end else begin
                                go = 1'b0;
                                if (r_pdone && (r_used == '0)) begin
                                    n_active  = 1'b0;
                                    n_pdone   = 1'b0;
                                    n_started = 1'b0;
                                    n_refill  = 1'b0;
                                    n_in_ur   = 1'b0;
                                    n_drained = 1'b1;
                                end
                            end
                        end
                        if (go) begin
                            priority if (r_used != '0) begin
                                pop        = 1'b1;
                                n_read_ptr = r_read_ptr + PTR_W'(1);
                                n_used     = r_used - FILL_W'(1);
                                n_in_ur    = 1'b0;
                            end else if (r_pdone) begin
                                n_active  = 1'b0;
                                n_pdone   = 1'b0;
                                n_started = 1'b0;
                                n_refill  = 1'b0;
                                n_in_ur   = 1'b0;
                                n_drained = 1'b1;
                            end else if (!n_in_ur) begin
                                n_in_ur   = 1'b1;
                                ur_event  = 1'b1;
                                n_started = 1'b0;
                                n_refill  = 1'b1;
                                if (r_ur_cnt != '1) begin
                                    n_ur_cnt = r_ur_cnt + 16'd1;
                                end
                            end else begin
                                n_in_ur = 1'b1;
                            end
                        end
                    end
                end
                OP_FINISH: begin
                    if (r_active) begin
                        n_pdone = 1'b1;
                        if (r_used == '0) begin
                            n_active  = 1'b0;
                            n_pdone   = 1'b0;
                            n_started = 1'b0;
                            n_refill  = 1'b0;
                            n_in_ur   = 1'b0;
                            n_drained = 1'b1;
                        end
                    end
                end
                OP_ABORT: begin
                    n_read_ptr  = '0;
                    n_write_ptr = '0;
                    n_used      = '0;
                    n_active    = 1'b0;
                    n_pdone     = 1'b0;
                    n_started   = 1'b0;
                    n_refill    = 1'b0;
                    n_in_ur     = 1'b0;
                    n_drained   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ring memory: at most one write per item; the read at the read pointer is unconditional
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[r_write_ptr] <= i_item.push_byte;
        end
        r_rd_data <= r_ring[r_read_ptr];
    end

    // session state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_ptr  <= '0;
            r_write_ptr <= '0;
            r_used      <= '0;
            r_active    <= 1'b0;
            r_pdone     <= 1'b0;
            r_started   <= 1'b0;
            r_refill    <= 1'b0;
            r_in_ur     <= 1'b0;
            r_drained   <= 1'b1;
            r_ur_cnt    <= '0;
        end else begin
            r_read_ptr  <= n_read_ptr;
            r_write_ptr <= n_write_ptr;
            r_used      <= n_used;
            r_active    <= n_active;
            r_pdone     <= n_pdone;
            r_started   <= n_started;
            r_refill    <= n_refill;
            r_in_ur     <= n_in_ur;
            r_drained   <= n_drained;
            r_ur_cnt    <= n_ur_cnt;
        end
    end

    // result strobe and per item flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_accepted  <= 1'b0;
            r_ur_event  <= 1'b0;
        end else begin
            r_res_valid <= take;
            r_out_valid <= pop;
            r_accepted  <= accepted;
            r_ur_event  <= ur_event;
        end
    end

    // result item
    assign o_result_valid = r_res_valid;
    always_comb begin
        o_result.out_byte       = r_out_valid ? r_rd_data : 8'd0;
        o_result.out_valid      = r_out_valid;
        o_result.accepted       = r_accepted;
        o_result.playing        = r_started;
        o_result.drained_flag   = r_drained;
        o_result.underrun_event = r_ur_event;
        o_result.underrun_total = r_ur_cnt;
        o_result.fill_level     = r_used;
        o_result.session_on     = r_active;
    end

`ifndef SYNTHESIS
    // fill level bounded by the ring
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FILL_W'(RING_BYTES))
        else $error("fill level beyond ring size");

    // pointers agree with the fill level
    a_ptr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PTR_W'(r_write_ptr - r_read_ptr) == r_used[PTR_W-1:0])
        else $error("pointer distance disagrees with fill level");

    // drained exactly when no session runs
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drained == !r_active)
        else $error("drained flag out of step with session");

    // playback only inside a session
    a_play_sess: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> r_active)
        else $error("playing without a session");

    // one result for every item taken
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_result_valid)
        else $error("item taken without a result");

    // a popped byte lowers the fill level by one
    a_pop_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_used == $past(r_used) - FILL_W'(1)))
        else $error("pop did not lower fill level");
`endif

endmodule

// ===== tb/sv/apjb_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// apjb_checker
// Watches the item, result and register ports of the audio playout jitter
// buffer, keeps its own copy of the ring and session state, predicts one
// result per item taken and compares it field by field.
// ---------------------------------------------------------------------------
module apjb_checker
    import apjb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  t_item               i_item,
    input  logic                i_result_valid,
    input  t_result             i_result,
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int unsigned MS_PER_S       = 1000;
    localparam int unsigned BYTES_PER_TICK = 4;

    // live register copy
    logic [RATE_W-1:0] cfg_rate;
    logic [MS_W-1:0]   cfg_prebuf;
    logic [MS_W-1:0]   cfg_refill;
    logic [MIN_W-1:0]  cfg_min;

    // ring and session copy
    logic [7:0]        sample_ring [RING_BYTES];
    logic [PTR_W-1:0]  rd_ptr;
    logic [PTR_W-1:0]  wr_ptr;
    logic [FILL_W-1:0] fill;
    logic              sess_on;
    logic              prod_done;
    logic              playing;
    logic              refill_wait;
    logic              in_ur;
    logic              drained;
    logic [15:0]       ur_count;

    t_result due_results_q [$];
    int      fails = 0;

    function automatic logic rate_in_band();
        return cfg_rate >= RATE_LO && cfg_rate <= RATE_HI;
    endfunction

    // fill level needed before playback (re)starts
    function automatic longint unsigned start_level();
        longint unsigned bps;
        longint unsigned lvl;
        bps = rate_in_band() ? longint'(cfg_rate) * BYTES_PER_TICK : 0;
        if (refill_wait) begin
            lvl = bps * cfg_refill / MS_PER_S;
        end else begin
            if (bps == 0)
                return 0;
            lvl = bps * cfg_prebuf / MS_PER_S;
            if (lvl > RING_HALF)
                lvl = RING_HALF;
        end
        if (lvl < cfg_min)
            lvl = cfg_min;
        return lvl;
    endfunction

    function automatic void empty_ring();
        rd_ptr = '0;
        wr_ptr = '0;
        fill   = '0;
    endfunction

    function automatic void close_session();
        sess_on     = 1'b0;
        prod_done   = 1'b0;
        playing     = 1'b0;
        refill_wait = 1'b0;
        in_ur       = 1'b0;
        drained     = 1'b1;
    endfunction

    function automatic void reset_model();
        cfg_rate   = '0;
        cfg_prebuf = PREBUF_MS_RST;
        cfg_refill = REFILL_MS_RST;
        cfg_min    = MIN_START_RST;
        empty_ring();
        close_session();
        ur_count = '0;
    endfunction

    // one audio event applied to the state, returns the result it shows
    function automatic t_result apply_audio_event(t_item it);
        t_result r;
        logic    hold;
        r    = '0;
        hold = 1'b0;
        case (t_op'(it.op))
            OP_START: begin
                if (rate_in_band()) begin
                    empty_ring();
                    sess_on     = 1'b1;
                    prod_done   = 1'b0;
                    playing     = 1'b0;
                    refill_wait = 1'b0;
                    in_ur       = 1'b0;
                    drained     = 1'b0;
                    r.accepted  = 1'b1;
                end
            end
            OP_PUSH: begin
                if (sess_on && fill < RING_BYTES) begin
                    sample_ring[wr_ptr] = it.push_byte;
                    wr_ptr     = wr_ptr + 1'b1;
                    fill       = fill + 1'b1;
                    r.accepted = 1'b1;
                end
            end
            OP_PULL: begin
                if (sess_on) begin
                    // waiting for prebuffer or refill
                    if (!playing || refill_wait) begin
                        if (fill >= start_level() || (prod_done && fill != 0)) begin
                            playing     = 1'b1;
                            refill_wait = 1'b0;
                            drained     = 1'b0;
                            in_ur       = 1'b0;
                        end else begin
                            hold = 1'b1;
                            if (prod_done && fill == 0)
                                close_session();
                        end
                    end
                    if (!hold) begin
                        if (fill != 0) begin
                            r.out_byte  = sample_ring[rd_ptr];
                            r.out_valid = 1'b1;
                            rd_ptr      = rd_ptr + 1'b1;
                            fill        = fill - 1'b1;
                            in_ur       = 1'b0;
                        end else if (prod_done) begin
                            close_session();
                        end else if (!in_ur) begin
                            in_ur = 1'b1;
                            if (ur_count != '1)
                                ur_count = ur_count + 1'b1;
                            r.underrun_event = 1'b1;
                            playing          = 1'b0;
                            refill_wait      = 1'b1;
                        end
                    end
                end
            end
            OP_FINISH: begin
                if (sess_on) begin
                    prod_done = 1'b1;
                    if (fill == 0)
                        close_session();
                end
            end
            OP_ABORT: begin
                empty_ring();
                close_session();
            end
            default: ;
        endcase
        r.playing        = playing;
        r.drained_flag   = drained;
        r.underrun_total = ur_count;
        r.fill_level     = fill;
        r.session_on     = sess_on;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            fails++;
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
        end
    endtask

    // sample every port at the clock edge, before the design updates
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            reset_model();
            due_results_q.delete();
        end else begin
            if (i_result_valid) begin
                if (due_results_q.size() == 0) begin
                    fails++;
                    $error("result strobe with no item outstanding");
                end else begin
                    want = due_results_q.pop_front();
                    check_field("out_byte", 32'(want.out_byte),
                                32'(i_result.out_byte));
                    check_field("out_valid", 32'(want.out_valid),
                                32'(i_result.out_valid));
                    check_field("accepted", 32'(want.accepted),
                                32'(i_result.accepted));
                    check_field("playing", 32'(want.playing),
                                32'(i_result.playing));
                    check_field("drained_flag", 32'(want.drained_flag),
                                32'(i_result.drained_flag));
                    check_field("underrun_event", 32'(want.underrun_event),
                                32'(i_result.underrun_event));
                    check_field("underrun_total", 32'(want.underrun_total),
                                32'(i_result.underrun_total));
                    check_field("fill_level", 32'(want.fill_level),
                                32'(i_result.fill_level));
                    check_field("session_on", 32'(want.session_on),
                                32'(i_result.session_on));
                end
            end
            if (i_start && !i_busy)
                due_results_q.push_back(apply_audio_event(i_item));
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SAMPLE_RATE: cfg_rate   = i_cfg_data[RATE_W-1:0];
                    CFG_PREBUF_MS:   cfg_prebuf = i_cfg_data[MS_W-1:0];
                    CFG_REFILL_MS:   cfg_refill = i_cfg_data[MS_W-1:0];
                    CFG_MIN_START:   cfg_min    = i_cfg_data[MIN_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_results_q.size();
    end

endmodule

// ===== tb/sv/audio_playout_jitter_buffer_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// audio_playout_jitter_buffer_tb
// Drives audio events into the playout buffer: a directed pass over refused
// events, prebuffer, underrun, refill, drain and abort, then random sessions
// under several register settings and idle patterns. A checker beside the
// design predicts every result.
// ---------------------------------------------------------------------------
module audio_playout_jitter_buffer_tb;
    import apjb_pkg::*;

    localparam logic [2:0] OP_RSVD_FIRST = 3'(OP_ABORT) + 3'd1;
    localparam logic [2:0] OP_RSVD_LAST  = '1;
    localparam int         RAND_ITEMS    = 1050;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                start    = 1'b0;
    logic                busy;
    t_item               item     = '0;
    logic                res_valid;
    t_result             result;
    logic                cfg_we   = 1'b0;
    logic [CIDX_W-1:0]   cfg_idx  = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    int                  fail_count;
    int                  pending;

    int unsigned         idle_pct  = 0;
    int unsigned         items_sent = 0;

    // clock, 4 ns period
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    audio_playout_jitter_buffer DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (item),
        .o_result_valid (res_valid),
        .o_result       (result),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    apjb_checker u_playout_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (item),
        .i_result_valid (res_valid),
        .i_result       (result),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // offer one item, optionally after a random idle gap
    task automatic send(input logic [2:0] op, input logic [7:0] b);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start <= 1'b1;
        item  <= t_item'{op: op, push_byte: b};
        @(posedge clk);
        while (busy) @(posedge clk);
        if (op < OP_RSVD_FIRST)
            items_sent++;
    endtask

    task automatic send_rsvd();
        send(OP_RSVD_FIRST + 3'($urandom_range(0, OP_RSVD_LAST - OP_RSVD_FIRST)),
             8'($urandom));
    endtask

    // hold off until every outstanding item has its result
    task automatic wait_drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // program all four registers while the block is idle
    task automatic write_cfg(input t_cfg c);
        wait_drain();
        cfg_we <= 1'b1;
        put_reg(CFG_SAMPLE_RATE, CFG_W'(c.sample_rate));
        put_reg(CFG_PREBUF_MS,   CFG_W'(c.prebuffer_ms));
        put_reg(CFG_REFILL_MS,   CFG_W'(c.refill_ms));
        put_reg(CFG_MIN_START,   CFG_W'(c.min_start_bytes));
        cfg_we <= 1'b0;
    endtask

    // one mostly well-formed session with random content and some noise
    task automatic random_session(input int unsigned span);
        int unsigned pushes;
        int unsigned pick;
        pushes = 0;
        send(OP_START, 8'($urandom));
        repeat (span) begin
            if ($urandom_range(0, 99) == 0)
                wait_drain();
            pick = $urandom_range(0, 99);
            if (pick < 48) begin
                send(OP_PUSH, 8'($urandom));
                pushes++;
            end else if (pick < 90) begin
                send(OP_PULL, 8'($urandom));
            end else if (pick < 93) begin
                send(OP_FINISH, 8'($urandom));
            end else if (pick < 95) begin
                send(OP_ABORT, 8'($urandom));
            end else if (pick < 97) begin
                send(OP_START, 8'($urandom));
            end else begin
                send_rsvd();
            end
        end
        // finish, then pull once per push, at most 60 times, plus two more pulls
        send(OP_FINISH, 8'($urandom));
        repeat ((pushes > 60 ? 60 : pushes) + 2)
            send(OP_PULL, 8'($urandom));
    endtask

    task automatic run_phase(input t_cfg c, input int unsigned pct, input int unsigned upto);
        write_cfg(c);
        idle_pct = pct;
        while (items_sent < upto)
            random_session($urandom_range(8, 60));
    endtask

    // run length guard
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // no session yet, reset rate is out of band
        send(OP_START, 8'h00);
        send(OP_PUSH, 8'hFF);
        send(OP_PULL, 8'h00);
        send(OP_FINISH, 8'h00);
        send(OP_ABORT, 8'h00);
        send(OP_RSVD_LAST, 8'hFF);

        // lowest rate, both thresholds floored at three bytes
        write_cfg(t_cfg'{RATE_LO, 12'd0, 12'd0, 17'd3});
        send(OP_START, 8'h00);
        send(OP_PULL, 8'h00);
        send(OP_PUSH, 8'h00);
        send(OP_PUSH, 8'hFF);
        send(OP_PUSH, 8'h5A);
        send(OP_PULL, 8'h00);
        send(OP_PULL, 8'h00);
        send(OP_PULL, 8'h00);
        send(OP_PULL, 8'h00);      // underrun
        send(OP_PULL, 8'h00);      // refill pending, no second count
        send(OP_PUSH, 8'hA5);
        send(OP_FINISH, 8'h00);
        send(OP_PULL, 8'h00);      // producer done with data, plays
        send(OP_PULL, 8'h00);      // empty after finish, drained
        send(OP_START, 8'h00);
        send(OP_FINISH, 8'h00);    // finish on empty ring
        send(OP_START, 8'h00);
        send(OP_PUSH, 8'h11);
        send(OP_START, 8'h00);     // restart drops the ring
        send(OP_PUSH, 8'h22);

        // rate made invalid inside a running session
        write_cfg(t_cfg'{16'hFFFF, 12'd0, 12'd0, 17'd3});
        send(OP_PULL, 8'h00);
        send(OP_PULL, 8'h00);
        send(OP_PULL, 8'h00);
        send(OP_ABORT, 8'h00);
        send(OP_START, 8'h00);     // refused

        // random sessions over several settings and idle patterns
        items_sent = 0;
        run_phase(t_cfg'{RATE_LO,    12'd1, 12'd1, 17'd0},  34, RAND_ITEMS / 6);
        run_phase(t_cfg'{16'd11025,  12'd2, 12'd1, 17'd20}, 34, RAND_ITEMS / 3);
        run_phase(t_cfg'{RATE_HI,    12'd0, 12'd0, 17'd0},  60, RAND_ITEMS / 2);
        run_phase(t_cfg'{16'd16000,  12'd1, 12'd3, 17'd5},  60, RAND_ITEMS * 2 / 3);
        run_phase(t_cfg'{16'd48001,  12'd4000, 12'd4000, 17'd65536}, 0,
                  RAND_ITEMS * 2 / 3 + 40);
        run_phase(t_cfg'{RATE_LO,    12'd2, 12'd0, 17'd0},  0,  RAND_ITEMS * 5 / 6);
        run_phase(t_cfg'{16'd32000,  12'd3, 12'd2, 17'd100}, 0, RAND_ITEMS);

        wait_drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/apjb_pkg.sv
rtl/apjb_thresh.sv
rtl/audio_playout_jitter_buffer.sv
tb/sv/apjb_checker.sv
tb/sv/audio_playout_jitter_buffer_tb.sv
